// ===== rtl/kisn_pkg.sv =====
`timescale 1ns / 1ps

package kisn_pkg;

	// number of mixing steps, three rounds of eight
	localparam int unsigned NUM_STEPS = 24;

	localparam logic [31:0] MIX_C2 = 32'o13240474631;
	localparam logic [31:0] MIX_C3 = 32'o15666365641;

	localparam logic [31:0] EPOCH_SECS   = 32'd300;
	localparam int unsigned LOW_BITS     = 24;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// floor(x / 300) = floor((x >> 2) * DIV75_MAGIC >> DIV75_SHIFT), exact for 32-bit x
	localparam logic [30:0] DIV75_MAGIC = 31'd1832519380;
	localparam int unsigned DIV75_SHIFT = 37;

	typedef enum logic [2:0] {
		REG_KEY_IN_3_4    = 3'd0,
		REG_KEY_IN_5_6    = 3'd1,
		REG_KEY_IN_7      = 3'd2,
		REG_KEY_STATE_0_1 = 3'd3,
		REG_KEY_STATE_2_3 = 3'd4
	} cfg_reg_t;

	typedef logic [3:0][31:0] mix_state_t;
	typedef logic [7:0][31:0] mix_words_t;

	typedef struct packed {
		logic [63:0] in_3_4;
		logic [63:0] in_5_6;
		logic [31:0] in_7;
		logic [63:0] st_0_1;
		logic [63:0] st_2_3;
	} key_t;

	// one classified request, front to back
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] port_word;
		logic [31:0] now_sec;
		logic [19:0] now_usec;
		logic [31:0] rekey_sec;
		logic        rekeyed;
	} req_t;

	typedef struct packed {
		logic [31:0] seq_num;
		logic        rekeyed;
	} res_t;

	localparam logic [2:0] WORD_ORDER [NUM_STEPS] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd1, 3'd3, 3'd5, 3'd7, 3'd0, 3'd2, 3'd4, 3'd6,
		3'd3, 3'd7, 3'd2, 3'd6, 3'd1, 3'd5, 3'd0, 3'd4
	};

	localparam logic [4:0] ROT_AMOUNT [3][4] = '{
		'{5'd3, 5'd7, 5'd11, 5'd19},
		'{5'd3, 5'd5, 5'd9,  5'd13},
		'{5'd3, 5'd9, 5'd11, 5'd15}
	};

	// one step of the half-MD4 mix
	function automatic mix_state_t mix_step(input logic [4:0] step, input mix_state_t v,
		input mix_words_t w);
		logic [1:0]  rnd;
		logic [1:0]  t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] f;
		logic [31:0] k;
		logic [31:0] s;
		logic [4:0]  rot;
		mix_state_t  r;
		rnd = step[4:3];
		t   = 2'd0 - step[1:0];
		x   = v[t + 2'd1];
		y   = v[t + 2'd2];
		z   = v[t + 2'd3];
		unique case (rnd)
			2'd0: begin
				f = z ^ (x & (y ^ z));
				k = '0;
			end
			2'd1: begin
				// majority; the two terms never share a set bit
				f = (x & y) | ((x ^ y) & z);
				k = MIX_C2;
			end
			default: begin
				f = x ^ y ^ z;
				k = MIX_C3;
			end
		endcase
		rot  = ROT_AMOUNT[rnd][step[1:0]];
		s    = v[t] + f + w[WORD_ORDER[step]] + k;
		r    = v;
		r[t] = (s << rot) | (s >> (6'd32 - {1'b0, rot}));
		return r;
	endfunction

endpackage

// ===== rtl/kisn_fifo.sv =====
`timescale 1ns / 1ps

// small synchronous queue, DEPTH >= 2
module kisn_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/kisn_front.sv =====
`timescale 1ns / 1ps

// takes requests, decides on rekey and tracks the last rekey time
module kisn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               queue_full,
	input  logic [31:0]        src_addr,
	input  logic [31:0]        dst_addr,
	input  logic [15:0]        src_port,
	input  logic [15:0]        dst_port,
	input  logic [31:0]        now_sec,
	input  logic [19:0]        now_usec,
	output logic               req_push,
	output kisn_pkg::req_t     req
);

	import kisn_pkg::*;

	logic [31:0] last_rekey_q;
	logic [31:0] elapsed;
	logic        rekey;

	assign req_push = push && !queue_full;
	// wraps, so time running backwards by any amount rekeys too
	assign elapsed  = now_sec - last_rekey_q;
	assign rekey    = (last_rekey_q == '0) || (elapsed > EPOCH_SECS);

	always_comb begin
		req.src_addr  = src_addr;
		req.dst_addr  = dst_addr;
		req.port_word = {src_port, dst_port};
		req.now_sec   = now_sec;
		req.now_usec  = now_usec;
		req.rekey_sec = rekey ? now_sec : last_rekey_q;
		req.rekeyed   = rekey;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rekey_q <= '0;
		end else if (req_push && rekey) begin
			last_rekey_q <= now_sec;
		end
	end

endmodule

// ===== rtl/kisn_back.sv =====
`timescale 1ns / 1ps

// time arithmetic, 24-step mix pipeline and final sum; stalls as a whole on res_full
module kisn_back (
	input  logic           clk,
	input  logic           arst_n,
	input  kisn_pkg::key_t keys,
	input  kisn_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_pop,
	output kisn_pkg::res_t res,
	output logic           res_push,
	input  logic           res_full
);

	import kisn_pkg::*;

	typedef struct packed {
		mix_state_t  v;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] base;
		logic        rekeyed;
	} stage_t;

	logic                 en;
	logic [60:0]          div_prod;
	logic                 pre_valid_s1;
	req_t                 pre_req_s1;
	logic [31:0]          sec_mul_s1;
	logic [7:0]           epoch_s1;
	stage_t               stg_s [NUM_STEPS + 1];
	logic [NUM_STEPS:0]   stg_valid_s;
	logic [31:0]          hash_b;

	assign en       = !res_full;
	assign req_pop  = en && req_valid;
	assign div_prod = 61'(req.rekey_sec[31:2]) * 61'(DIV75_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_s1 <= 1'b0;
			stg_valid_s  <= '0;
		end else if (en) begin
			pre_valid_s1 <= req_valid;
			stg_valid_s  <= {stg_valid_s[NUM_STEPS-1:0], pre_valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_req_s1 <= req;
			sec_mul_s1 <= 32'(req.now_sec * USEC_PER_SEC);
			epoch_s1   <= div_prod[DIV75_SHIFT+7:DIV75_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0].v       <= {keys.st_2_3[63:32], keys.st_2_3[31:0],
				keys.st_0_1[63:32], keys.st_0_1[31:0]};
			stg_s[0].w0      <= pre_req_s1.src_addr;
			stg_s[0].w1      <= pre_req_s1.dst_addr;
			stg_s[0].w2      <= pre_req_s1.port_word;
			stg_s[0].base    <= {epoch_s1, {LOW_BITS{1'b0}}} + sec_mul_s1
				+ 32'(pre_req_s1.now_usec);
			stg_s[0].rekeyed <= pre_req_s1.rekeyed;
		end
	end

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
		mix_words_t w;
		stage_t     nxt;

		always_comb begin
			w     = {keys.in_7, keys.in_5_6[63:32], keys.in_5_6[31:0],
				keys.in_3_4[63:32], keys.in_3_4[31:0],
				stg_s[i].w2, stg_s[i].w1, stg_s[i].w0};
			nxt   = stg_s[i];
			nxt.v = mix_step(5'(i), stg_s[i].v, w);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i+1] <= nxt;
			end
		end
	end

	assign hash_b      = keys.st_0_1[63:32] + stg_s[NUM_STEPS].v[1];
	assign res.seq_num = 32'(hash_b[LOW_BITS-1:0]) + stg_s[NUM_STEPS].base;
	assign res.rekeyed = stg_s[NUM_STEPS].rekeyed;
	assign res_push    = en && stg_valid_s[NUM_STEPS];

endmodule

// ===== rtl/keyed_tcp_isn_generator.sv =====
`timescale 1ns / 1ps

// Keyed TCP initial sequence number generator (half-MD4 mix).
//
// Request side is a queue write port: a transaction is taken when push is
// high and full is low. Result side is a queue read port: while empty is low
// the oldest result sits on seq_num/rekeyed; pop with empty low takes it.
// Key registers are written over cfg_valid/cfg_ready (ready is always high),
// cfg_index selecting the register; only write them while the block is idle.
//
// Throughput: one request per cycle while full is low. A request passes the
// request queue, the time-arithmetic registers, the 24-stage mix pipeline
// and the result queue before its result shows on the read port.
// The front decides on rekey at accept time, so rekey state is updated in
// request order without waiting on the hash.
//
// Reset clears both queues, the key registers and the last rekey time; the
// first request after reset always rekeys.
// When the reader stalls, the two-entry result queue fills, the whole back
// pipeline freezes, the request queue fills and full rises.
module keyed_tcp_isn_generator #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        push,
	output logic        full,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [31:0] now_sec,
	input  logic [19:0] now_usec,
	// result channel
	output logic        empty,
	input  logic        pop,
	output logic [31:0] seq_num,
	output logic        rekeyed,
	// key register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	import kisn_pkg::*;

	localparam int unsigned REQ_W   = $bits(req_t);
	localparam int unsigned RES_W   = $bits(res_t);
	localparam int unsigned RES_DEPTH = 2;

	key_t             keys_q;
	req_t             front_req;
	logic             front_push;
	logic [REQ_W-1:0] mid_rdata;
	req_t             mid_req;
	logic             mid_empty;
	logic             back_pop;
	res_t             back_res;
	logic             back_push;
	logic             res_full;
	logic [RES_W-1:0] res_rdata;
	res_t             res_head;

	// key registers; indices beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_IN_3_4:    keys_q.in_3_4 <= cfg_data;
				REG_KEY_IN_5_6:    keys_q.in_5_6 <= cfg_data;
				REG_KEY_IN_7:      keys_q.in_7   <= cfg_data[31:0];
				REG_KEY_STATE_0_1: keys_q.st_0_1 <= cfg_data;
				REG_KEY_STATE_2_3: keys_q.st_2_3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	kisn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.queue_full (full),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.src_port   (src_port),
		.dst_port   (dst_port),
		.now_sec    (now_sec),
		.now_usec   (now_usec),
		.req_push   (front_push),
		.req        (front_req)
	);

	// decoupling queue between front and back
	kisn_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (REQ_W)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_req),
		.full   (full),
		.pop    (back_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_req = req_t'(mid_rdata);

	// back: hash and sum
	kisn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.keys      (keys_q),
		.req       (mid_req),
		.req_valid (!mid_empty),
		.req_pop   (back_pop),
		.res       (back_res),
		.res_push  (back_push),
		.res_full  (res_full)
	);

	// result queue parts the pipeline from the reader
	kisn_fifo #(
		.DEPTH (RES_DEPTH),
		.WIDTH (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign res_head = res_t'(res_rdata);
	assign seq_num  = res_head.seq_num;
	assign rekeyed  = res_head.rekeyed;

endmodule

// ===== rtl/kisn_checker.sv =====
`timescale 1ns / 1ps

module kisn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] seq_num,
	input logic        rekeyed
);

	logic [7:0] inflight_q;
	logic       first_done_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = push && !full;
	assign acc_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			first_done_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 8'(acc_in) - 8'(acc_out);
			if (acc_out) begin
				first_done_q <= 1'b1;
			end
		end
	end

	// no result without a pending request
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> inflight_q != '0)
		else $error("result shown with nothing in flight");

	// back-pressure only with work pending
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> inflight_q != '0)
		else $error("full raised while idle");

	// head result holds until taken
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(seq_num) && $stable(rekeyed)))
		else $error("waiting result changed");

	// first request after reset always starts an epoch
	a_first_rekey: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !first_done_q) |-> rekeyed)
		else $error("first result not flagged as rekey");

endmodule

bind keyed_tcp_isn_generator kisn_checker u_kisn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.seq_num  (seq_num),
	.rekeyed  (rekeyed)
);
